/* design/srtf_pkg.sv */
// Package for the shortest-remaining-time-first scheduler: widths, defaults and shared types.
package srtf_pkg;

   localparam int MAX_PROCESSES_DEF = 16;
   localparam int BURST_BITS_DEF    = 16;

   localparam int CFG_BITS     = 5;
   localparam int SLOT_BITS    = 4;
   localparam int ARRIVAL_BITS = 16;
   localparam int BURST_IN_BITS = 16;
   localparam int TICK_BITS    = 32;

   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 40;

   // Item kinds carried on the request tuser bit.
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // Control part of the candidate that travels along the row of cells.
   // live_count counts used slots with work left, saturating at two.
   typedef struct packed {
      logic       valid;
      logic       found;
      logic [1:0] live_count;
   } srtf_flags_type;

endpackage

/* design/srtf_cell.sv */
// One process slot of the scheduler and its stage of the candidate chain.
module srtf_cell #(
   parameter int INDEX      = 0,
   parameter int SLOT_W     = 4,
   parameter int BURST_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [srtf_pkg::CFG_BITS-1:0]      process_count,
   input  logic [srtf_pkg::TICK_BITS-1:0]     tick,
   input  logic                               wr_en,
   input  logic [SLOT_W-1:0]                  wr_slot,
   input  logic [srtf_pkg::ARRIVAL_BITS-1:0]  wr_arrival,
   input  logic [BURST_BITS-1:0]              wr_burst,
   input  logic                               dec_en,
   input  logic [SLOT_W-1:0]                  dec_slot,
   input  srtf_pkg::srtf_flags_type           flags_in,
   input  logic [SLOT_W-1:0]                  slot_in,
   input  logic [BURST_BITS-1:0]              rem_in,
   input  logic [srtf_pkg::ARRIVAL_BITS-1:0]  arrival_in,
   input  logic [BURST_BITS-1:0]              burst_in,
   output srtf_pkg::srtf_flags_type           flags_out,
   output logic [SLOT_W-1:0]                  slot_out,
   output logic [BURST_BITS-1:0]              rem_out,
   output logic [srtf_pkg::ARRIVAL_BITS-1:0]  arrival_out,
   output logic [BURST_BITS-1:0]              burst_out
);
   import srtf_pkg::*;

   localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(INDEX);

   logic [ARRIVAL_BITS-1:0] arrival_ff;
   logic [BURST_BITS-1:0]   burst_ff;
   logic [BURST_BITS-1:0]   rem_ff, rem_in_next;

   srtf_flags_type          flags_ff, flags_in_next;
   logic [SLOT_W-1:0]       slot_ff;
   logic [BURST_BITS-1:0]   crem_ff;
   logic [ARRIVAL_BITS-1:0] carr_ff;
   logic [BURST_BITS-1:0]   cburst_ff;

   logic used, live, ready, better, take;

   always_comb begin
      used   = int'(process_count) > INDEX;
      live   = used && (rem_ff != '0);
      ready  = live && (TICK_BITS'(arrival_ff) <= tick);
      // This slot sits above every slot already seen, so a full tie keeps the candidate.
      better = (rem_ff < rem_in) ||
               ((rem_ff == rem_in) && ((arrival_ff < arrival_in) ||
                ((arrival_ff == arrival_in) && (burst_ff < burst_in))));
      take   = ready && (!flags_in.found || better);

      flags_in_next       = flags_in;
      flags_in_next.found = flags_in.found || ready;
      if (live && flags_in.live_count != 2'd2) begin
         flags_in_next.live_count = flags_in.live_count + 2'd1;
      end

      rem_in_next = rem_ff;
      if (wr_en && wr_slot == MY_SLOT) begin
         rem_in_next = wr_burst;
      end else if (dec_en && dec_slot == MY_SLOT) begin
         rem_in_next = rem_ff - BURST_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff   <= '0;
         flags_ff <= '0;
      end else begin
         rem_ff <= rem_in_next;
         // Only the valid bit drops after the transfer; the verdict stays readable.
         if (flags_in.valid) begin
            flags_ff <= flags_in_next;
         end else begin
            flags_ff.valid <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && wr_slot == MY_SLOT) begin
         arrival_ff <= wr_arrival;
         burst_ff   <= wr_burst;
      end
      // The candidate payload holds once the transfer has passed, so the row's end stays readable.
      if (flags_in.valid) begin
         if (take) begin
            slot_ff   <= MY_SLOT;
            crem_ff   <= rem_ff;
            carr_ff   <= arrival_ff;
            cburst_ff <= burst_ff;
         end else begin
            slot_ff   <= slot_in;
            crem_ff   <= rem_in;
            carr_ff   <= arrival_in;
            cburst_ff <= burst_in;
         end
      end
   end

   assign flags_out   = flags_ff;
   assign slot_out    = slot_ff;
   assign rem_out     = crem_ff;
   assign arrival_out = carr_ff;
   assign burst_out   = cburst_ff;

endmodule

/* design/srtf_process_scheduler.sv */
// Shortest-remaining-time-first scheduler: sequencer, row of slot cells and the result register.
//
// Usage: process_count is written on the csr channel (csr_valid/csr_ready, csr_data) while idle.
// Request items arrive on req_*: req_tuser selects a load (0) or a time tick (1), req_tdata
// carries the slot, arrival time and burst time of a load. Every item gives exactly one
// response on rsp_*, holding the slot that ran, the completion flag, the time after the item
// and whether all used slots are complete.
// Each item sends one candidate through the row of MAX_PROCESSES cells, one cell per cycle;
// the best slot and a count of slots with work left arrive at the end of the row.
// An item's candidate runs through the row of cells, and its result is then loaded into the
// output register and presented; the next request is taken when that response has been loaded,
// so items do not overlap and the row of cells sets the rate.
// The response sits in an output register, so a new request is accepted while it waits.
// If the receiver stalls, the finished item holds at the end of the row until the output
// register is free; nothing is lost.
// Reset clears the remaining work of all slots, the time and process_count; arrival and
// burst times are undefined until a slot is loaded, and such a slot is never chosen.
module srtf_process_scheduler #(
   parameter int MAX_PROCESSES = srtf_pkg::MAX_PROCESSES_DEF,
   parameter int BURST_BITS    = srtf_pkg::BURST_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [srtf_pkg::CFG_BITS-1:0]        csr_data,      // process_count
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [srtf_pkg::REQ_DATA_BITS-1:0]   req_tdata,     // slot, arrival, burst
   input  logic                                 req_tuser,     // func
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [srtf_pkg::RSP_DATA_BITS-1:0]   rsp_tdata      // ran, ran_slot, finished,
                                                               // time_after, all_done
);
   import srtf_pkg::*;

   localparam int SLOT_W = (MAX_PROCESSES > 2) ? $clog2(MAX_PROCESSES) : 1;
   localparam int IDX_W  = (SLOT_W > SLOT_BITS) ? SLOT_W : SLOT_BITS;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [CFG_BITS-1:0]  process_count_ff;
   logic [TICK_BITS-1:0] tick_ff, tick_in, tick_next;
   logic                 kind_ff;
   logic                 start_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic req_accept, load_accept, out_free, finish_go;
   logic wr_en, dec_en;

   logic [SLOT_BITS-1:0]     req_slot;
   logic [ARRIVAL_BITS-1:0]  req_arrival;
   logic [BURST_IN_BITS-1:0] req_burst;
   logic [SLOT_W-1:0]        wr_slot;
   logic [BURST_BITS-1:0]    wr_burst;

   logic                 ran, finished, all_done;
   logic [SLOT_BITS-1:0] ran_slot;
   logic [IDX_W-1:0]     pick_ext;

   srtf_flags_type          chain_flags   [MAX_PROCESSES+1];
   logic [SLOT_W-1:0]       chain_slot    [MAX_PROCESSES+1];
   logic [BURST_BITS-1:0]   chain_rem     [MAX_PROCESSES+1];
   logic [ARRIVAL_BITS-1:0] chain_arrival [MAX_PROCESSES+1];
   logic [BURST_BITS-1:0]   chain_burst   [MAX_PROCESSES+1];

   assign req_slot    = req_tdata[SLOT_BITS-1:0];
   assign req_arrival = req_tdata[SLOT_BITS +: ARRIVAL_BITS];
   assign req_burst   = req_tdata[SLOT_BITS+ARRIVAL_BITS +: BURST_IN_BITS];

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign load_accept = req_accept && (req_tuser == FUNC_LOAD);

   assign pick_ext = IDX_W'(chain_slot[MAX_PROCESSES]);
   assign wr_slot  = SLOT_W'(req_slot);
   assign wr_burst = BURST_BITS'(req_burst);
   assign wr_en    = load_accept && (int'(req_slot) < MAX_PROCESSES);

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign finish_go = (state_ff == ST_FINISH) && out_free;
   assign dec_en    = finish_go && (kind_ff == FUNC_TICK) && chain_flags[MAX_PROCESSES].found;

   // The head of the row receives a fresh, empty candidate.
   assign chain_flags[0]   = '{valid: start_ff, found: 1'b0, live_count: 2'd0};
   assign chain_slot[0]    = '0;
   assign chain_rem[0]     = '0;
   assign chain_arrival[0] = '0;
   assign chain_burst[0]   = '0;

   for (genvar i = 0; i < MAX_PROCESSES; i++) begin : g_cell
      srtf_cell #(
         .INDEX      (i),
         .SLOT_W     (SLOT_W),
         .BURST_BITS (BURST_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .process_count (process_count_ff),
         .tick          (tick_ff),
         .wr_en         (wr_en),
         .wr_slot       (wr_slot),
         .wr_arrival    (req_arrival),
         .wr_burst      (wr_burst),
         .dec_en        (dec_en),
         .dec_slot      (chain_slot[MAX_PROCESSES]),
         .flags_in      (chain_flags[i]),
         .slot_in       (chain_slot[i]),
         .rem_in        (chain_rem[i]),
         .arrival_in    (chain_arrival[i]),
         .burst_in      (chain_burst[i]),
         .flags_out     (chain_flags[i+1]),
         .slot_out      (chain_slot[i+1]),
         .rem_out       (chain_rem[i+1]),
         .arrival_out   (chain_arrival[i+1]),
         .burst_out     (chain_burst[i+1])
      );
   end

   always_comb begin
      tick_next = (tick_ff != '1) ? tick_ff + TICK_BITS'(1) : tick_ff;

      ran      = 1'b0;
      ran_slot = '0;
      finished = 1'b0;
      all_done = (chain_flags[MAX_PROCESSES].live_count == 2'd0);
      if (kind_ff == FUNC_TICK && chain_flags[MAX_PROCESSES].found) begin
         ran      = 1'b1;
         ran_slot = pick_ext[SLOT_BITS-1:0];
         finished = (chain_rem[MAX_PROCESSES] == BURST_BITS'(1));
         // The chosen slot was one of the live ones, so its completion may finish the set.
         if (finished && chain_flags[MAX_PROCESSES].live_count == 2'd1) begin
            all_done = 1'b1;
         end
      end

      rsp_data_in = {{(RSP_DATA_BITS-TICK_BITS-SLOT_BITS-3){1'b0}}, all_done,
                     ((kind_ff == FUNC_TICK) ? tick_next : tick_ff),
                     finished, ran_slot, ran};

      tick_in = tick_ff;
      if (load_accept) begin
         tick_in = '0;
      end else if (finish_go && kind_ff == FUNC_TICK) begin
         tick_in = tick_next;
      end

      rsp_valid_in = rsp_valid_ff;
      if (finish_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (chain_flags[MAX_PROCESSES].valid) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         process_count_ff <= '0;
         tick_ff          <= '0;
         start_ff         <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         start_ff     <= req_accept;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            process_count_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff <= req_tuser;
      end
      if (finish_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
